// ===== rtl/kec_pkg.sv =====
// kec_pkg: shared types and constants of the kruskal edge classifier
// transaction payload structs, edge class codes, store and epoch sizes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kec_pkg;

  localparam int unsigned NumVertices = 1024;
  localparam int unsigned VtxW        = $clog2(NumVertices);
  localparam int unsigned EpochW      = 4;
  localparam int unsigned EntryW      = EpochW + VtxW;
  localparam int unsigned CountW      = 16;
  localparam int unsigned ClassW      = 2;

  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochLast  = {EpochW{1'b1}};
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  localparam logic [ClassW-1:0] ClassForest  = 2'd0;
  localparam logic [ClassW-1:0] ClassCycle   = 2'd1;
  localparam logic [ClassW-1:0] ClassSkipped = 2'd2;

  typedef logic [VtxW-1:0] vtx_t;

  typedef struct packed {
    logic [9:0] vertex_a;
    logic [9:0] vertex_b;
    logic       known_cycle;
    logic       last_edge;
  } in_t;

  typedef struct packed {
    logic [ClassW-1:0] edge_class;
    logic [CountW-1:0] cycle_count;
    logic [CountW-1:0] skipped_count;
    logic              done_res;
  } out_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = (c == CountMax) ? CountMax : c + CountW'(1);
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kruskal_edge_classifier.sv =====
// kruskal_edge_classifier: union-find classification of weight-sorted edges
// root walk sequencer around one parent ram, counters and output register
// depends on kec_pkg and kec_ram
`timescale 1ns / 1ps
`default_nettype none

// usage:
// edges enter on the in channel (in_valid_i/in_ready_o, payload in_data_i) and
// one result per edge leaves on the out channel (out_valid_o/out_ready_i,
// payload out_data_o), in order. one edge is worked on at a time.
// a flagged edge goes straight to the finish state; its result is loaded there
// once the output register is free, and the next edge can then be accepted.
// any other edge walks from each endpoint to its root in the parent ram, each
// visited node taking a registered ram read, then a compare; its result is
// loaded in the finish state after both walks. the new link is written in the
// compare that finds the second endpoint's root, if the two roots differ.
// each entry carries an epoch tag; a graph's last edge moves to a new epoch,
// which returns the store to identity at once. after reset, and after every
// 15th graph when the epoch wraps, a clearing pass writes all 1024 entries,
// one per cycle; in_ready_o stays low until the pass is done.
// a finished result sits in the output register until taken; while the
// receiver stalls the next edge is still accepted and walked, and its result
// waits until the register frees.

module kruskal_edge_classifier (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire kec_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output kec_pkg::out_t      out_data_o
);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRdA   = 3'd2;
  localparam logic [2:0] SCkA   = 3'd3;
  localparam logic [2:0] SRdB   = 3'd4;
  localparam logic [2:0] SCkB   = 3'd5;
  localparam logic [2:0] SFin   = 3'd6;

  logic [2:0]                   state_q, state_d;
  kec_pkg::in_t                 edge_q, edge_d;
  kec_pkg::vtx_t                node_q, node_d;
  kec_pkg::vtx_t                root_a_q, root_a_d;
  logic [kec_pkg::ClassW-1:0]   cls_q, cls_d;
  kec_pkg::vtx_t                clr_idx_q, clr_idx_d;
  logic [kec_pkg::EpochW-1:0]   epoch_q, epoch_d;
  logic [kec_pkg::CountW-1:0]   cycles_q, cycles_d;
  logic [kec_pkg::CountW-1:0]   skipped_q, skipped_d;
  logic                         out_valid_q, out_valid_d;
  kec_pkg::out_t                out_q, out_d;

  logic                         mem_we;
  kec_pkg::vtx_t                mem_addr;
  logic [kec_pkg::EntryW-1:0]   mem_wdata;
  logic [kec_pkg::EntryW-1:0]   mem_rdata;

  logic                         in_acc;
  logic                         load;
  kec_pkg::vtx_t                up;
  logic                         at_root;
  logic [kec_pkg::CountW-1:0]   cyc_new, skp_new;

  kec_ram #(
    .Width (kec_pkg::EntryW),
    .Depth (kec_pkg::NumVertices)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // stale epoch tag reads as identity
  assign up = (mem_rdata[kec_pkg::VtxW +: kec_pkg::EpochW] == epoch_q)
              ? mem_rdata[kec_pkg::VtxW-1:0] : node_q;
  assign at_root = (up == node_q);

  assign in_ready_o  = (state_q == SIdle);
  assign in_acc      = in_valid_i && in_ready_o;
  assign load        = (state_q == SFin) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign cyc_new = (cls_q == kec_pkg::ClassCycle) ? kec_pkg::sat_inc(cycles_q) : cycles_q;
  assign skp_new = (cls_q == kec_pkg::ClassSkipped) ? kec_pkg::sat_inc(skipped_q) : skipped_q;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = node_q;
    mem_wdata = {epoch_q, root_a_q};
    case (state_q)
      SClear: begin
        mem_we    = 1'b1;
        mem_addr  = clr_idx_q;
        mem_wdata = '0;
      end
      SCkB: begin
        mem_we = at_root && (node_q != root_a_q);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    edge_d      = edge_q;
    node_d      = node_q;
    root_a_d    = root_a_q;
    cls_d       = cls_q;
    clr_idx_d   = clr_idx_q;
    epoch_d     = epoch_q;
    cycles_d    = cycles_q;
    skipped_d   = skipped_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      SClear: begin
        clr_idx_d = clr_idx_q + kec_pkg::VtxW'(1);
        if (clr_idx_q == {kec_pkg::VtxW{1'b1}}) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (in_acc) begin
          edge_d = in_data_i;
          node_d = in_data_i.vertex_a[kec_pkg::VtxW-1:0];
          if (in_data_i.known_cycle) begin
            cls_d   = kec_pkg::ClassSkipped;
            state_d = SFin;
          end else begin
            state_d = SRdA;
          end
        end
      end
      SRdA: begin
        state_d = SCkA;
      end
      SCkA: begin
        if (at_root) begin
          root_a_d = node_q;
          node_d   = edge_q.vertex_b[kec_pkg::VtxW-1:0];
          state_d  = SRdB;
        end else begin
          node_d  = up;
          state_d = SRdA;
        end
      end
      SRdB: begin
        state_d = SCkB;
      end
      SCkB: begin
        if (at_root) begin
          cls_d   = (node_q != root_a_q) ? kec_pkg::ClassForest : kec_pkg::ClassCycle;
          state_d = SFin;
        end else begin
          node_d  = up;
          state_d = SRdB;
        end
      end
      SFin: begin
        if (load) begin
          out_valid_d         = 1'b1;
          out_d.edge_class    = cls_q;
          out_d.cycle_count   = cyc_new;
          out_d.skipped_count = skp_new;
          out_d.done_res      = edge_q.last_edge;
          state_d             = SIdle;
          if (edge_q.last_edge) begin
            cycles_d  = '0;
            skipped_d = '0;
            if (epoch_q == kec_pkg::EpochLast) begin
              epoch_d   = kec_pkg::EpochFirst;
              clr_idx_d = '0;
              state_d   = SClear;
            end else begin
              epoch_d = epoch_q + kec_pkg::EpochW'(1);
            end
          end else begin
            cycles_d  = cyc_new;
            skipped_d = skp_new;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      clr_idx_q   <= '0;
      epoch_q     <= kec_pkg::EpochFirst;
      cycles_q    <= '0;
      skipped_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      epoch_q     <= epoch_d;
      cycles_q    <= cycles_d;
      skipped_q   <= skipped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    edge_q   <= edge_d;
    node_q   <= node_d;
    root_a_q <= root_a_d;
    cls_q    <= cls_d;
    out_q    <= out_d;
  end

  // ram is written only by the clearing pass or by a link at the end of a walk
  a_write_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == SClear) || (state_q == SCkB && at_root))
    else $error("parent ram written outside clear or link");

  // a link never makes a root its own parent
  a_link_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q == SCkB) |-> (mem_addr != mem_wdata[kec_pkg::VtxW-1:0]))
    else $error("self link written");

  // the epoch never takes the value left by the clearing pass
  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch matches cleared tag");

  // the last edge of a graph leaves both counters at zero
  a_graph_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && edge_q.last_edge) |=> (cycles_q == '0) && (skipped_q == '0))
    else $error("counters not cleared after last edge");

  // a result is loaded only into a free or draining output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== rtl/kec_ram.sv =====
// kec_ram: generic single-port synchronous ram with registered read
// one access per cycle: old word read out, wdata_i written on we_i
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kec_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ===== bench/kec_checker.sv =====
// kec_checker: scoreboard for the kruskal edge classifier
// keeps its own union-find table and counters, predicts each edge's verdict
// and compares every out-channel transaction; depends on kec_pkg
`timescale 1ns / 1ps

module kec_checker
  import kec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);

  vtx_t              parent_tbl [NumVertices];
  logic [CountW-1:0] cycles_seen;
  logic [CountW-1:0] skips_seen;
  out_t              edge_verdicts [$];
  out_t              want;
  out_t              got;

  initial begin
    fail_count_o  = 0;
    outstanding_o = 0;
  end

  function automatic void forget_graph();
    int v;
    for (v = 0; v < NumVertices; v++) begin
      parent_tbl[v] = vtx_t'(v);
    end
    cycles_seen = '0;
    skips_seen  = '0;
  endfunction

  function automatic vtx_t find_root(input vtx_t v);
    vtx_t node;
    int   hops;
    node = v;
    for (hops = 0; hops < NumVertices; hops++) begin
      if (parent_tbl[node] == node) break;
      node = parent_tbl[node];
    end
    return node;
  endfunction

  function automatic out_t classify_edge(input in_t e);
    out_t r;
    vtx_t ra;
    vtx_t rb;
    r = '0;
    if (e.known_cycle) begin
      if (skips_seen != CountMax) skips_seen = skips_seen + 1'b1;
      r.edge_class = ClassSkipped;
    end else begin
      ra = find_root(e.vertex_a);
      rb = find_root(e.vertex_b);
      if (ra != rb) begin
        parent_tbl[rb] = ra;
        r.edge_class = ClassForest;
      end else begin
        if (cycles_seen != CountMax) cycles_seen = cycles_seen + 1'b1;
        r.edge_class = ClassCycle;
      end
    end
    r.cycle_count   = cycles_seen;
    r.skipped_count = skips_seen;
    r.done_res      = e.last_edge;
    if (e.last_edge) forget_graph();
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s expected %0d actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forget_graph();
      edge_verdicts.delete();
    end else begin
      // results are matched before new edges are queued: a result can never
      // belong to an edge taken in the same cycle
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (edge_verdicts.size() == 0) begin
          $error("unexpected transaction edge_class %0d cycle_count %0d skipped_count %0d",
                 got.edge_class, got.cycle_count, got.skipped_count);
          fail_count_o++;
        end else begin
          want = edge_verdicts.pop_front();
          check_field("edge_class", 32'(want.edge_class), 32'(got.edge_class));
          check_field("cycle_count", 32'(want.cycle_count), 32'(got.cycle_count));
          check_field("skipped_count", 32'(want.skipped_count), 32'(got.skipped_count));
          check_field("done_res", 32'(want.done_res), 32'(got.done_res));
        end
      end
      if (in_valid_i && in_ready_i) begin
        edge_verdicts.push_back(classify_edge(in_data_i));
      end
    end
    outstanding_o = edge_verdicts.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus and verdict for the kruskal edge classifier
// drives directed and random edge streams under idling;
// depends on kec_pkg, kruskal_edge_classifier and kec_checker
`timescale 1ns / 1ps

module tb_top;
  import kec_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 400;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready;
  out_t        out_data;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;

  kruskal_edge_classifier i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  kec_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_data_i    (out_data),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  function automatic in_t make_edge(input vtx_t a, input vtx_t b, input logic flag,
                                    input logic last);
    in_t e;
    e.vertex_a    = a;
    e.vertex_b    = b;
    e.known_cycle = flag;
    e.last_edge   = last;
    return e;
  endfunction

  task automatic send_edge(input in_t e);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = e;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_graph(output int unsigned sent);
    int unsigned kind;
    int unsigned len;
    int unsigned pool;
    int unsigned chain_len;
    int unsigned i;
    vtx_t        base;
    vtx_t        a;
    vtx_t        b;
    logic        flag;
    kind      = $urandom_range(9, 0);
    len       = $urandom_range(30, 1);
    pool      = $urandom_range(16, 2);
    chain_len = len * 2 / 3;
    base      = vtx_t'($urandom);
    for (i = 0; i < len; i++) begin
      flag = ($urandom_range(99, 0) < 12);
      if (kind < 4) begin
        // dense pool of a few vertices, wrapping around the top of the range
        a = base + vtx_t'($urandom_range(pool - 1, 0));
        b = base + vtx_t'($urandom_range(pool - 1, 0));
      end else if (kind < 6) begin
        // deep chain, then edges that close cycles through it
        if (i < chain_len) begin
          a = base + vtx_t'(i + 1);
          b = base + vtx_t'(i);
        end else begin
          a = base;
          b = base + vtx_t'($urandom_range(chain_len, 0));
        end
      end else if (kind < 8) begin
        a    = vtx_t'($urandom);
        b    = vtx_t'($urandom);
        flag = ($urandom_range(99, 0) < 20);
      end else begin
        a    = vtx_t'($urandom);
        b    = $urandom_range(1, 0) ? a : vtx_t'($urandom);
        flag = 1'($urandom_range(1, 0));
      end
      send_edge(make_edge(a, b, flag, i == len - 1));
    end
    sent = len;
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                           input int unsigned items);
    int unsigned total;
    int unsigned n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    total = 0;
    while (total < items) begin
      send_random_graph(n);
      total += n;
    end
  endtask

  task automatic send_directed();
    int unsigned i;
    send_edge(make_edge(10'd0, 10'd1023, 1'b0, 1'b0));
    send_edge(make_edge(10'd1023, 10'd0, 1'b0, 1'b0));
    send_edge(make_edge(10'd5, 10'd5, 1'b0, 1'b0));
    send_edge(make_edge(10'd1023, 10'd1023, 1'b1, 1'b0));
    send_edge(make_edge(10'd0, 10'd0, 1'b1, 1'b0));
    send_edge(make_edge(10'd1, 10'd2, 1'b0, 1'b0));
    send_edge(make_edge(10'd2, 10'd0, 1'b0, 1'b0));
    send_edge(make_edge(10'd1023, 10'd1, 1'b0, 1'b0));
    send_edge(make_edge(10'd682, 10'd341, 1'b1, 1'b1));
    // store must be back to identity here
    send_edge(make_edge(10'd1023, 10'd0, 1'b0, 1'b0));
    send_edge(make_edge(10'd341, 10'd682, 1'b0, 1'b1));
    send_edge(make_edge(10'd7, 10'd7, 1'b0, 1'b1));
    send_edge(make_edge(10'd3, 10'd3, 1'b1, 1'b1));
    for (i = 0; i < 4; i++) begin
      send_edge(make_edge(vtx_t'(i + 1), vtx_t'(i), 1'b0, 1'b0));
    end
    send_edge(make_edge(10'd0, 10'd4, 1'b0, 1'b0));
    send_edge(make_edge(10'd0, 10'd1023, 1'b0, 1'b1));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 29;
    recv_idle_pct = 66;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_directed();
    run_phase(29, 66, 170);
    run_phase(66, 29, 170);
    run_phase(0, 0, 170);

    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
